// ===== rtl/core/spool_pkg.sv =====
package spool_pkg;

    localparam int POOL_SLOTS = 32;
    localparam int SLOT_W     = 5;
    localparam int LINK_W     = 6;
    localparam int TIME_W     = 31;

    localparam logic [LINK_W-1:0] SLOT_NONE = 6'h3F;

    localparam logic [1:0] FUNC_ALLOC = 2'd0;
    localparam logic [1:0] FUNC_FREE  = 2'd1;
    localparam logic [1:0] FUNC_SWEEP = 2'd2;

    localparam logic [2:0] EV_ALLOC   = 3'd0;
    localparam logic [2:0] EV_EVICT   = 3'd1;
    localparam logic [2:0] EV_FREED   = 3'd2;
    localparam logic [2:0] EV_EXPIRED = 3'd3;
    localparam logic [2:0] EV_DONE    = 3'd4;
    localparam logic [2:0] EV_ERROR   = 3'd5;

    typedef struct packed {
        logic [1:0]        func;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] now_time;
        logic [TIME_W-1:0] lifetime;
    } t_req;

    typedef struct packed {
        logic [2:0]        event_kind;
        logic [SLOT_W-1:0] slot_index;
        logic              last;
    } t_rsp;

    typedef enum logic [3:0] {
        OP_NONE     = 4'd0,
        OP_LOAD     = 4'd1,
        OP_RELEASE  = 4'd2,
        OP_ALLOC    = 4'd3,
        OP_LOAD_REF = 4'd4
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [SLOT_W-1:0] slot;
    } t_cmd;

    typedef struct packed {
        logic              free_empty;
        logic              list_empty;
        logic [LINK_W-1:0] free_head;
        logic [LINK_W-1:0] oldest;
        logic [LINK_W-1:0] newest;
        logic              active;
        logic              same_birth;
        logic              expired;
        logic [LINK_W-1:0] older;
    } t_sts;

endpackage

// ===== rtl/core/spool_datapath.sv =====
module spool_datapath
    import spool_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [TIME_W-1:0] i_now_time,
    input  logic [TIME_W-1:0] i_lifetime,
    output t_sts              o_sts
);

    logic [LINK_W-1:0] r_next [POOL_SLOTS];
    logic [LINK_W-1:0] r_prev [POOL_SLOTS];
    logic [TIME_W-1:0] r_birth [POOL_SLOTS];
    logic [TIME_W-1:0] r_life [POOL_SLOTS];
    logic [POOL_SLOTS-1:0] r_act;
    logic [LINK_W-1:0] r_free;
    logic [LINK_W-1:0] r_new;
    logic [LINK_W-1:0] r_old;
    logic [TIME_W-1:0] r_ref_birth;
    logic [TIME_W-1:0] r_l_birth;
    logic [TIME_W:0]   r_l_end;
    logic [LINK_W-1:0] r_l_next;
    logic [LINK_W-1:0] r_l_prev;
    logic              r_l_act;

    logic [SLOT_W-1:0] s;
    logic [LINK_W-1:0] s6;
    logic [SLOT_W-1:0] fh;

    assign s  = i_cmd.slot;
    assign s6 = {1'b0, s};
    assign fh = r_free[SLOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < POOL_SLOTS; i++) begin
                r_next[i] <= (i + 1 < POOL_SLOTS) ? LINK_W'(i + 1) : SLOT_NONE;
                r_prev[i] <= '0;
                r_birth[i] <= '0;
                r_life[i] <= '0;
            end
            r_act <= '0;
            r_free <= '0;
            r_new <= SLOT_NONE;
            r_old <= SLOT_NONE;
        end else begin
            unique case (i_cmd.op)
                OP_LOAD, OP_LOAD_REF: begin
                    r_l_birth <= r_birth[s];
                    r_l_end <= {1'b0, r_birth[s]} + {1'b0, r_life[s]};
                    r_l_next <= r_next[s];
                    r_l_prev <= r_prev[s];
                    r_l_act <= r_act[s];
                    if (i_cmd.op == OP_LOAD_REF) begin
                        r_ref_birth <= r_birth[s];
                    end
                end
                OP_RELEASE: begin
                    if (r_new == s6) begin
                        r_new <= r_l_next;
                    end else if (!r_l_prev[LINK_W-1]) begin
                        r_next[r_l_prev[SLOT_W-1:0]] <= r_l_next;
                    end
                    if (r_old == s6) begin
                        r_old <= r_l_prev;
                    end else if (!r_l_next[LINK_W-1]) begin
                        r_prev[r_l_next[SLOT_W-1:0]] <= r_l_prev;
                    end
                    r_act[s] <= 1'b0;
                    r_prev[s] <= '0;
                    r_next[s] <= r_free;
                    r_free <= s6;
                end
                OP_ALLOC: begin
                    r_free <= r_next[fh];
                    r_birth[fh] <= i_now_time;
                    r_life[fh] <= i_lifetime;
                    r_act[fh] <= 1'b1;
                    r_prev[fh] <= SLOT_NONE;
                    r_next[fh] <= r_new;
                    if (!r_new[LINK_W-1]) begin
                        r_prev[r_new[SLOT_W-1:0]] <= r_free;
                    end else begin
                        r_old <= r_free;
                    end
                    r_new <= r_free;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_sts.free_empty = r_free[LINK_W-1];
        o_sts.list_empty = r_old[LINK_W-1];
        o_sts.free_head  = r_free;
        o_sts.oldest     = r_old;
        o_sts.newest     = r_new;
        o_sts.active     = r_l_act;
        o_sts.same_birth = (r_l_birth == r_ref_birth);
        o_sts.expired    = ({1'b0, i_now_time} > r_l_end);
        o_sts.older      = r_l_next;
    end

endmodule

// ===== rtl/core/spool_ctrl.sv =====
module spool_ctrl
    import spool_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_valid,
    input  logic i_cfg_data,
    output logic o_cfg_ready,
    input  logic i_req_valid,
    input  t_req i_req,
    output logic o_req_ready,
    output t_rsp o_rsp,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_cmd o_cmd,
    output logic [TIME_W-1:0] o_now_time,
    output logic [TIME_W-1:0] o_lifetime,
    input  t_sts i_sts
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_EVLOAD = 8'b00000010,
        S_EVCHK  = 8'b00000100,
        S_ALLOC  = 8'b00001000,
        S_FRLOAD = 8'b00010000,
        S_FRCHK  = 8'b00100000,
        S_SWLOAD = 8'b01000000,
        S_SWCHK  = 8'b10000000
    } t_state;

    t_state r_state, n_state;
    t_req   r_req;
    logic   r_sweep_en;
    logic   r_rsp_valid;
    t_rsp   r_rsp;
    logic [SLOT_W-1:0] r_cur, n_cur;
    logic [LINK_W-1:0] r_guard, n_guard;
    logic   r_first, n_first;
    logic   emit;
    t_rsp   n_rsp;

    assign o_cfg_ready = 1'b1;
    assign o_req_ready = r_state == S_IDLE && !r_rsp_valid;
    assign o_rsp = r_rsp;
    assign o_rsp_valid = r_rsp_valid;
    assign o_now_time = r_req.now_time;
    assign o_lifetime = r_req.lifetime;

    always_comb begin
        n_state = r_state;
        n_cur = r_cur;
        n_guard = r_guard;
        n_first = r_first;
        emit = 1'b0;
        n_rsp = r_rsp;
        o_cmd.op = OP_NONE;
        o_cmd.slot = r_cur;
        if (!r_rsp_valid || i_rsp_ready) begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid && o_req_ready) begin
                        n_cur = (i_req.func == FUNC_SWEEP) ? i_sts.newest[SLOT_W-1:0]
                                                           : i_req.slot;
                        n_guard = i_sts.newest;
                        n_first = 1'b1;
                        unique case (i_req.func)
                            FUNC_ALLOC: n_state = S_ALLOC;
                            FUNC_FREE:  n_state = S_FRLOAD;
                            FUNC_SWEEP: n_state = S_SWLOAD;
                            default:    n_state = S_IDLE;
                        endcase
                    end
                end
                S_EVLOAD: begin
                    if (i_sts.list_empty) begin
                        n_state = S_ALLOC;
                    end else begin
                        if (r_first) begin
                            o_cmd.op = OP_LOAD_REF;
                        end else begin
                            o_cmd.op = OP_LOAD;
                        end
                        o_cmd.slot = i_sts.oldest[SLOT_W-1:0];
                        n_cur = i_sts.oldest[SLOT_W-1:0];
                        n_first = 1'b0;
                        n_state = S_EVCHK;
                    end
                end
                S_EVCHK: begin
                    if (i_sts.same_birth) begin
                        o_cmd.op = OP_RELEASE;
                        emit = 1'b1;
                        n_rsp = '{EV_EVICT, r_cur, 1'b0};
                        n_state = S_EVLOAD;
                    end else begin
                        n_state = S_ALLOC;
                    end
                end
                S_ALLOC: begin
                    if (!i_sts.free_empty) begin
                        o_cmd.op = OP_ALLOC;
                        n_rsp = '{EV_ALLOC, i_sts.free_head[SLOT_W-1:0], 1'b1};
                    end else if (!i_sts.list_empty) begin
                        n_state = S_EVLOAD;
                    end else begin
                        n_rsp = '{EV_ERROR, '0, 1'b1};
                    end
                    if (!i_sts.free_empty || i_sts.list_empty) begin
                        emit = 1'b1;
                        n_state = S_IDLE;
                    end
                end
                S_FRLOAD: begin
                    o_cmd.op = OP_LOAD;
                    n_state = S_FRCHK;
                end
                S_FRCHK: begin
                    emit = 1'b1;
                    n_state = S_IDLE;
                    if (i_sts.active) begin
                        o_cmd.op = OP_RELEASE;
                        n_rsp = '{EV_FREED, r_cur, 1'b1};
                    end else begin
                        n_rsp = '{EV_ERROR, r_cur, 1'b1};
                    end
                end
                S_SWLOAD: begin
                    if (r_guard[LINK_W-1] || !r_sweep_en) begin
                        emit = 1'b1;
                        n_rsp = '{EV_DONE, '0, 1'b1};
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.op = OP_LOAD;
                        n_state = S_SWCHK;
                    end
                end
                S_SWCHK: begin
                    n_cur = i_sts.older[SLOT_W-1:0];
                    n_guard = i_sts.older;
                    n_state = S_SWLOAD;
                    if (i_sts.expired) begin
                        o_cmd.op = OP_RELEASE;
                        emit = 1'b1;
                        n_rsp = '{EV_EXPIRED, r_cur, 1'b0};
                    end
                end
                default: n_state = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sweep_en <= 1'b1;
            r_rsp_valid <= 1'b0;
            r_first <= 1'b0;
            r_guard <= SLOT_NONE;
        end else begin
            if (i_cfg_valid) begin
                r_sweep_en <= i_cfg_data;
            end
            if (emit) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
            r_state <= n_state;
            r_cur <= n_cur;
            r_guard <= n_guard;
            r_first <= n_first;
            r_rsp <= n_rsp;
            if (i_req_valid && o_req_ready) begin
                r_req <= i_req;
            end
        end
    end

endmodule

// ===== rtl/core/slot_pool_with_oldest_eviction_unit.sv =====
// Channel | Dir | Handshake            | Payload
// cfg     | in  | i_cfg_valid/ready    | i_cfg_data (sweep enable)
// request | in  | i_req_valid/ready    | i_req (t_req)
// result  | out | o_rsp_valid/ready    | o_rsp (t_rsp)
// One request at a time. Alloc takes the head of the free list; with the pool full,
// it first evicts every slot sharing the oldest birth time, loading and checking each.
// Free loads the slot, then checks it. A sweep loads and checks each active slot, newest first.
// Each result waits in the output register; a stalled result holds the walk.
// Synchronous active-low reset restores the empty pool, sweeps enabled.
module slot_pool_with_oldest_eviction_unit
    import spool_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic i_cfg_data,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    t_cmd cmd;
    t_sts sts;
    logic [TIME_W-1:0] now_time;
    logic [TIME_W-1:0] lifetime;

    spool_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_data, .o_cfg_ready,
        .i_req_valid, .i_req, .o_req_ready, .o_rsp, .o_rsp_valid, .i_rsp_ready,
        .o_cmd(cmd), .o_now_time(now_time), .o_lifetime(lifetime), .i_sts(sts)
    );

    spool_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_now_time(now_time),
        .i_lifetime(lifetime), .o_sts(sts)
    );

endmodule

// ===== sim/slot_pool_with_oldest_eviction_unit_checker.sv =====
module slot_pool_with_oldest_eviction_unit_checker
    import spool_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_valid,
    input  logic     i_cfg_ready,
    input  logic     i_cfg_data,
    input  logic     i_req_valid,
    input  logic     i_req_ready,
    input  t_req     i_req,
    input  logic     i_rsp_valid,
    input  logic     i_rsp_ready,
    input  t_rsp     i_rsp,
    output int       o_fail_count,
    output int       o_pending
);

    logic [LINK_W-1:0] older_of [POOL_SLOTS];
    logic [LINK_W-1:0] newer_of [POOL_SLOTS];
    logic [TIME_W-1:0] born_at [POOL_SLOTS];
    logic [TIME_W-1:0] span_of [POOL_SLOTS];
    logic              in_use [POOL_SLOTS];
    logic [LINK_W-1:0] pool_head;
    logic [LINK_W-1:0] newest;
    logic [LINK_W-1:0] oldest;
    logic              sweep_on;
    t_rsp              expected_events[$];
    int                fails;
    int                pending_n;

    assign o_fail_count = fails;
    assign o_pending    = pending_n;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fails++;
    endtask

    task automatic push_event(input logic [2:0] kind, input logic [SLOT_W-1:0] idx);
        t_rsp r;
        r.event_kind = kind;
        r.slot_index = idx;
        r.last       = 1'b0;
        expected_events.push_back(r);
    endtask

    task automatic unlink_slot(input logic [LINK_W-1:0] s);
        logic [LINK_W-1:0] nw;
        logic [LINK_W-1:0] od;
        nw = newer_of[s];
        od = older_of[s];
        if (newest == s) newest = od;
        else if (nw < POOL_SLOTS) older_of[nw] = od;
        if (oldest == s) oldest = nw;
        else if (od < POOL_SLOTS) newer_of[od] = nw;
        in_use[s]   = 1'b0;
        newer_of[s] = '0;
        older_of[s] = pool_head;
        pool_head   = s;
    endtask

    task automatic predict_request(input t_req q);
        int                start_count;
        logic [TIME_W-1:0] t0;
        logic [LINK_W-1:0] s;
        logic [LINK_W-1:0] cur;
        logic [LINK_W-1:0] nxt;
        int                guard;
        start_count = expected_events.size();
        if (q.func == FUNC_ALLOC) begin
            if (pool_head >= POOL_SLOTS && oldest < POOL_SLOTS) begin
                t0 = born_at[oldest];
                while (oldest < POOL_SLOTS && born_at[oldest] == t0) begin
                    s = oldest;
                    unlink_slot(s);
                    push_event(EV_EVICT, s[SLOT_W-1:0]);
                end
            end
            if (pool_head >= POOL_SLOTS) begin
                push_event(EV_ERROR, '0);
            end else begin
                s           = pool_head;
                pool_head   = older_of[s];
                born_at[s]  = q.now_time;
                span_of[s]  = q.lifetime;
                in_use[s]   = 1'b1;
                newer_of[s] = SLOT_NONE;
                older_of[s] = newest;
                if (newest < POOL_SLOTS) newer_of[newest] = s;
                else oldest = s;
                newest = s;
                push_event(EV_ALLOC, s[SLOT_W-1:0]);
            end
        end else if (q.func == FUNC_FREE) begin
            if (in_use[q.slot]) begin
                unlink_slot({1'b0, q.slot});
                push_event(EV_FREED, q.slot);
            end else begin
                push_event(EV_ERROR, q.slot);
            end
        end else if (q.func == FUNC_SWEEP) begin
            if (sweep_on) begin
                cur   = newest;
                guard = 0;
                while (cur < POOL_SLOTS && guard < POOL_SLOTS) begin
                    nxt = older_of[cur];
                    if ({1'b0, q.now_time} > {1'b0, born_at[cur]} + {1'b0, span_of[cur]}) begin
                        unlink_slot(cur);
                        push_event(EV_EXPIRED, cur[SLOT_W-1:0]);
                    end
                    cur = nxt;
                    guard++;
                end
            end
            push_event(EV_DONE, '0);
        end
        if (expected_events.size() > start_count)
            expected_events[expected_events.size()-1].last = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            for (int i = 0; i < POOL_SLOTS; i++) begin
                older_of[i] = (i + 1 < POOL_SLOTS) ? LINK_W'(i + 1) : SLOT_NONE;
                newer_of[i] = '0;
                born_at[i]  = '0;
                span_of[i]  = '0;
                in_use[i]   = 1'b0;
            end
            pool_head = '0;
            newest    = SLOT_NONE;
            oldest    = SLOT_NONE;
            sweep_on  = 1'b1;
            expected_events.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) sweep_on = i_cfg_data;
            if (i_req_valid && i_req_ready) predict_request(i_req);
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_events.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %p", i_rsp));
                end else begin
                    want = expected_events.pop_front();
                    if (i_rsp.event_kind !== want.event_kind)
                        report_mismatch($sformatf("event_kind %0d, want %0d",
                            i_rsp.event_kind, want.event_kind));
                    if (i_rsp.slot_index !== want.slot_index)
                        report_mismatch($sformatf("slot_index %0d, want %0d",
                            i_rsp.slot_index, want.slot_index));
                    if (i_rsp.last !== want.last)
                        report_mismatch($sformatf("last %0d, want %0d",
                            i_rsp.last, want.last));
                end
            end
        end
        pending_n = expected_events.size();
    end

    initial begin
        fails     = 0;
        pending_n = 0;
    end

endmodule

// ===== sim/slot_pool_with_oldest_eviction_unit_test.sv =====
module slot_pool_with_oldest_eviction_unit_test;
    import spool_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic i_clk;
    logic i_rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_data;
    logic req_valid;
    logic req_ready;
    t_req req;
    logic rsp_valid;
    logic rsp_ready;
    t_rsp rsp;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    int   stall_phase;
    int   stall_mode;
    logic [TIME_W-1:0] clock_ms;

    slot_pool_with_oldest_eviction_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp)
    );

    slot_pool_with_oldest_eviction_unit_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_req_valid  (req_valid),
        .i_req_ready  (req_ready),
        .i_req        (req),
        .i_rsp_valid  (rsp_valid),
        .i_rsp_ready  (rsp_ready),
        .i_rsp        (rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // receiver stall pattern, with calm stretches
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (stall_phase % 64 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ready <= (stall_phase % 5 < 2);
            default: rsp_ready <= ($urandom_range(0, 1) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[slot_pool_with_oldest_eviction_unit] ERROR");
                $finish;
            end
        end
    end

    task automatic send_request(input logic [1:0] f, input logic [SLOT_W-1:0] s,
                                input logic [TIME_W-1:0] t, input logic [TIME_W-1:0] l);
        t_req r;
        r.func     = f;
        r.slot     = s;
        r.now_time = t;
        r.lifetime = l;
        req       <= r;
        req_valid <= 1'b1;
        do @(posedge i_clk); while (!(req_valid && req_ready));
        req_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_sweep_enable(input logic v);
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    task automatic random_request();
        int pick;
        logic [TIME_W-1:0] life;
        pick     = $urandom_range(0, 99);
        clock_ms = TIME_W'(clock_ms + $urandom_range(0, 40));
        life     = ($urandom_range(0, 9) == 0) ? TIME_W'($urandom)
                                               : TIME_W'($urandom_range(0, 200));
        if (pick < 50)
            send_request(FUNC_ALLOC, SLOT_W'($urandom), clock_ms, life);
        else if (pick < 75)
            send_request(FUNC_FREE, SLOT_W'($urandom), TIME_W'($urandom), TIME_W'($urandom));
        else if (pick < 95)
            send_request(FUNC_SWEEP, SLOT_W'($urandom), clock_ms, TIME_W'($urandom));
        else
            send_request(FUNC_UNUSED, SLOT_W'($urandom), TIME_W'($urandom),
                         TIME_W'($urandom));
    endtask

    initial begin
        int burst;
        i_rst_n     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        rsp_ready   = 1'b1;
        stall_phase = 0;
        stall_mode  = 0;
        idle_cycles = 0;
        clock_ms    = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_sweep_enable(1'b1);
        send_request(FUNC_FREE, 5'd0, '0, '0);
        send_request(FUNC_SWEEP, 5'd31, '1, '1);
        send_request(FUNC_UNUSED, 5'd31, '1, '1);
        send_request(FUNC_ALLOC, 5'd31, '1, '1);
        send_request(FUNC_ALLOC, 5'd0, '0, '0);
        send_request(FUNC_ALLOC, 5'd0, 31'd5, 31'd0);
        send_request(FUNC_FREE, 5'd1, '0, '0);
        send_request(FUNC_FREE, 5'd1, '0, '0);
        send_request(FUNC_SWEEP, 5'd0, '1, '0);
        // fill the pool with shared birth times, then force eviction
        for (int i = 0; i < 33; i++)
            send_request(FUNC_ALLOC, 5'd0, TIME_W'(i / 4), TIME_W'(10));
        write_sweep_enable(1'b0);
        send_request(FUNC_SWEEP, 5'd0, '1, '0);
        write_sweep_enable(1'b1);
        send_request(FUNC_SWEEP, 5'd0, 31'd12, '0);
        send_request(FUNC_SWEEP, 5'd0, '1, '0);

        for (int phase = 0; phase < 4; phase++) begin
            for (int n = 0; n < 60;) begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst && n < 60; b++, n++) random_request();
                if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
            write_sweep_enable(1'(phase % 2));
        end

        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("[slot_pool_with_oldest_eviction_unit] OK");
        else
            $display("[slot_pool_with_oldest_eviction_unit] ERROR");
        $finish;
    end

endmodule
